@@ hw/rtl/spf_pkg.sv @@
// Shared types and constants for the segment palette fader.
// Holds the FSM state type, register index codes and divider interface structs.
// No dependencies.
package spf_pkg;

  localparam int NUM_COLOURS = 4;
  localparam int DIVIDEND_W  = 18;
  localparam int DIVISOR_W   = 10;
  localparam int QUOT_W      = 8;

  localparam logic [2:0] REG_PALETTE_COUNT = 3'd0;
  localparam logic [2:0] REG_START_INDEX   = 3'd1;
  localparam logic [2:0] REG_SEGMENT_ID    = 3'd2;
  localparam logic [2:0] REG_FADE_STEPS    = 3'd3;
  localparam logic [2:0] REG_COLOUR_0      = 3'd4;
  localparam logic [2:0] REG_COLOUR_1      = 3'd5;
  localparam logic [2:0] REG_COLOUR_2      = 3'd6;
  localparam logic [2:0] REG_COLOUR_3      = 3'd7;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } spf_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } spf_div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } spf_div_rsp_t;

endpackage

@@ hw/rtl/spf_div.sv @@
// Restoring divider, one quotient bit per cycle, for the segment palette fader.
// Quotient is known to fit in QUOT_W bits. Depends on spf_pkg.
module spf_div import spf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  spf_div_req_t req,
  output spf_div_rsp_t rsp
);

  localparam int SW = $clog2(QUOT_W);

  logic [DIVIDEND_W-1:0] rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [QUOT_W-1:0]     quot;
  logic [SW-1:0]         step;
  logic                  busy;
  logic                  done;
  logic [DIVIDEND_W-1:0] trial;

  assign trial = DIVIDEND_W'(dvs) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.dividend;
      dvs  <= req.divisor;
      quot <= '0;
      step <= SW'(QUOT_W - 1);
    end else if (busy) begin
      if (rem >= trial) begin
        rem        <= rem - trial;
        quot[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

@@ hw/rtl/segment_palette_fader_core.sv @@
// Top level of the segment palette fader: config registers, fade sequencer, LED word output.
// Uses spf_pkg and one shared spf_div divider.
//
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------
// tick     | tick_valid/tick_ready  | tick
// led      | led_valid/led_ready    | led_index, red, green, blue, last
// cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// A tick with one palette colour goes from idle straight to the LED words; a fading tick
// first runs a start, eight divider steps and a done for each of the three channels.
// tick_ready is high only while idle; each led word holds until led_ready.
// Synchronous reset clears state; cfg_ready is always high.
module segment_palette_fader_core import spf_pkg::*; #(
  parameter int LEDS_PER_SEGMENT = 13,
  parameter int SEGMENT_STRIDE   = 14,
  parameter int PALETTE_SIZE     = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_ready,
  input  logic        tick,
  output logic        led_valid,
  input  logic        led_ready,
  output logic [9:0]  led_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int IW = (LEDS_PER_SEGMENT > 1) ? $clog2(LEDS_PER_SEGMENT) : 1;
  localparam logic [IW-1:0] LAST_I = IW'(LEDS_PER_SEGMENT - 1);
  localparam logic [2:0] LIM = (PALETTE_SIZE < NUM_COLOURS) ? 3'(PALETTE_SIZE)
                                                             : 3'(NUM_COLOURS);

  spf_state_t state, state_next;

  logic [2:0]  palette_count;
  logic [5:0]  segment_id;
  logic [9:0]  fade_steps;
  logic [23:0] colour_0, colour_1, colour_2, colour_3;
  logic [1:0]  palette_pos;
  logic [9:0]  fade_progress;

  logic [23:0] a_col, b_col, colour;
  logic [9:0]  p_lat, d_lat;
  logic [1:0]  ch;
  logic [IW-1:0] led_i;

  logic [2:0]  n_used, cur3, nxt3;
  logic [1:0]  cur, nxt;
  logic [9:0]  d_eff, p_eff;
  logic [10:0] p_inc;
  logic [23:0] cur_col, nxt_col;
  logic [7:0]  a_ch, b_ch, mag, q, v;
  logic        neg;
  logic [8:0]  sum9;
  logic [15:0] base16;
  logic        tick_acc;

  spf_div_req_t div_req;
  spf_div_rsp_t div_rsp;

  spf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign tick_ready = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign tick_acc   = tick_valid && tick_ready;
  assign led_valid  = (state == ST_EMIT);
  assign red        = colour[23:16];
  assign green      = colour[15:8];
  assign blue       = colour[7:0];

  always_comb begin
    n_used = palette_count;
    if (n_used == 3'd0) n_used = 3'd1;
    if (n_used > LIM)   n_used = LIM;
    cur3 = ({1'b0, palette_pos} < n_used) ? {1'b0, palette_pos} : 3'd0;
    nxt3 = (cur3 + 3'd1 < n_used) ? cur3 + 3'd1 : 3'd0;
    cur  = cur3[1:0];
    nxt  = nxt3[1:0];
    d_eff = (fade_steps == '0) ? 10'd1 : fade_steps;
    p_eff = (fade_progress > d_eff) ? d_eff : fade_progress;
    p_inc = {1'b0, p_eff} + 11'd1;
    base16 = 16'(segment_id) * 16'(SEGMENT_STRIDE);
  end

  always_comb begin
    case (cur)
      2'd0:    cur_col = colour_0;
      2'd1:    cur_col = colour_1;
      2'd2:    cur_col = colour_2;
      default: cur_col = colour_3;
    endcase
    case (nxt)
      2'd0:    nxt_col = colour_0;
      2'd1:    nxt_col = colour_1;
      2'd2:    nxt_col = colour_2;
      default: nxt_col = colour_3;
    endcase
  end

  always_comb begin
    case (ch)
      CH_RED: begin
        a_ch = a_col[23:16];
        b_ch = b_col[23:16];
      end
      CH_GREEN: begin
        a_ch = a_col[15:8];
        b_ch = b_col[15:8];
      end
      default: begin
        a_ch = a_col[7:0];
        b_ch = b_col[7:0];
      end
    endcase
    neg = (b_ch < a_ch);
    mag = neg ? (a_ch - b_ch) : (b_ch - a_ch);
    div_req.start    = (state == ST_MUL);
    div_req.dividend = DIVIDEND_W'(mag) * DIVIDEND_W'(p_lat);
    div_req.divisor  = d_lat;
    q    = div_rsp.quot;
    sum9 = {1'b0, a_ch} + {1'b0, q};
    if (neg) begin
      v = (q > a_ch) ? 8'd0 : (a_ch - q);
    end else begin
      v = sum9[8] ? 8'hFF : sum9[7:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick_acc && tick) state_next = (n_used == 3'd1) ? ST_EMIT : ST_MUL;
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) state_next = (ch == CH_BLUE) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (led_ready && last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      palette_count <= 3'd1;
      segment_id    <= 6'd0;
      fade_steps    <= 10'd50;
      colour_0      <= '0;
      colour_1      <= '0;
      colour_2      <= '0;
      colour_3      <= '0;
      palette_pos   <= 2'd0;
      fade_progress <= '0;
    end else begin
      state <= state_next;
      if (tick_acc && tick && n_used != 3'd1) begin
        if (p_inc > {1'b0, d_eff}) begin
          fade_progress <= '0;
          palette_pos   <= nxt;
        end else begin
          fade_progress <= p_inc[9:0];
          palette_pos   <= cur;
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PALETTE_COUNT: palette_count <= cfg_data[2:0];
          REG_START_INDEX: begin
            palette_pos   <= cfg_data[1:0];
            fade_progress <= '0;
          end
          REG_SEGMENT_ID:    segment_id <= cfg_data[5:0];
          REG_FADE_STEPS:    fade_steps <= cfg_data[9:0];
          REG_COLOUR_0:      colour_0   <= cfg_data;
          REG_COLOUR_1:      colour_1   <= cfg_data;
          REG_COLOUR_2:      colour_2   <= cfg_data;
          REG_COLOUR_3:      colour_3   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        a_col     <= cur_col;
        b_col     <= nxt_col;
        p_lat     <= p_eff;
        d_lat     <= d_eff;
        ch        <= CH_RED;
        colour    <= colour_0;
        led_index <= base16[9:0];
        led_i     <= '0;
        last      <= (LAST_I == '0);
      end
      ST_MUL: ;
      ST_DIV: begin
        if (div_rsp.done) begin
          case (ch)
            CH_RED:   colour[23:16] <= v;
            CH_GREEN: colour[15:8]  <= v;
            default:  colour[7:0]   <= v;
          endcase
          ch <= ch + 2'd1;
        end
      end
      ST_EMIT: begin
        if (led_ready && !last) begin
          led_index <= led_index + 10'd1;
          led_i     <= led_i + 1'b1;
          last      <= (led_i + 1'b1 == LAST_I);
        end
      end
      default: ;
    endcase
  end

endmodule
